// ===== sv/pip_pkg.sv =====
// shared types and constants for the point-in-polygon test core
// no dependencies; imported by every module of the block
package pip_pkg;

  // fixed field widths
  localparam int COORD_W   = 16;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int VERTEX_W  = 2 * COORD_W;
  localparam int TDATA_W   = 40;

  // selector codes carried on tuser
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TEST = 1'b1;

  // one edge handed to the edge unit
  typedef struct packed {
    logic               vld;
    logic               last;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] nx;
    logic [COORD_W-1:0] ny;
  } edge_req_t;

  // verdict for one edge
  typedef struct packed {
    logic vld;
    logic last;
    logic hit;
  } edge_rsp_t;

endpackage

// ===== sv/point_in_polygon_test_core.sv =====
// point-in-polygon test core: sequencer, vertex table and edge unit
// depends on pip_pkg, pip_vertex_mem and pip_edge_unit
//
// usage:
//   the slave stream takes one word per item; tuser selects a vertex load
//   (0) or a point test (1). a load writes one table slot in the cycle it
//   is accepted and gives no result; slots at or above MAX_VERTICES are
//   dropped. a test walks the table one vertex read per cycle, feeds each
//   edge to a two-stage compare unit and returns one master word with the
//   outside flag and the echoed point.
//   cfg_we_i writes vertex_count; counts above MAX_VERTICES are clamped.
//   write it and the table only while no test is in flight.
// sequencing:
//   a test reads its vertices through the single read port of the vertex
//   table; with fewer than two vertices in use it skips the walk and goes
//   straight to the result.
//   one item is worked on at a time.
// reset and stall:
//   reset clears the count and all control state; the table holds no valid
//   data until loaded. the result sits in an output register, so new items
//   are taken while it waits; a finished test holds until that register
//   frees up.
module point_in_polygon_test_core
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config
  input  logic               cfg_we_i,
  input  logic [CNT_W-1:0]   cfg_wdata_i,     // vertex_count
  // slave stream
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [TDATA_W-1:0] s_axis_tdata_i,  // vertex_index, coord_x, coord_y, pad
  input  logic               s_axis_tuser_i,  // func
  // master stream
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [TDATA_W-1:0] m_axis_tdata_o   // is_outside, point_x, point_y, pad
);

  localparam int ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW     = $clog2(MAX_VERTICES + 1);
  localparam int EXT_W  = (CW > CNT_W) ? CW : CNT_W;
  localparam int SW     = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;
  localparam int PAD_W  = TDATA_W - 1 - 2 * COORD_W;
  localparam logic [EXT_W-1:0] MAXV_EXT = EXT_W'(MAX_VERTICES);
  localparam logic [SW-1:0]    MAXV_SLT = SW'(MAX_VERTICES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_WAIT,
    ST_DONE
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   count_q;
  logic [CW-1:0]      nv_q, iss_q, nv_d;
  logic [EXT_W-1:0]   cnt_ext;
  logic               tag_vld_q, tag_first_q, tag_wrap_q;
  logic               par_q;
  logic [COORD_W-1:0] pt_x_q, pt_y_q;
  logic [COORD_W-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic               out_vld_q, out_outside_q;
  logic [COORD_W-1:0] out_x_q, out_y_q;

  logic               accept, is_load, slot_ok;
  logic [IDX_W-1:0]   in_slot;
  logic [COORD_W-1:0] in_x, in_y, rd_x, rd_y;
  logic               mem_we, mem_re;
  logic [VERTEX_W-1:0] rdata;
  edge_req_t          ereq;
  edge_rsp_t          ersp;

  // input word fields
  assign in_slot = s_axis_tdata_i[IDX_W-1:0];
  assign in_x    = s_axis_tdata_i[IDX_W +: COORD_W];
  assign in_y    = s_axis_tdata_i[IDX_W+COORD_W +: COORD_W];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign is_load         = (s_axis_tuser_i == FUNC_LOAD);
  assign slot_ok         = (SW'(in_slot) < MAXV_SLT);

  // clamp the vertex count to the table depth
  assign cnt_ext = EXT_W'(count_q);
  assign nv_d    = (cnt_ext > MAXV_EXT) ? CW'(MAXV_EXT) : CW'(cnt_ext);

  // table access
  assign mem_we = accept && is_load && slot_ok;
  assign mem_re = (state_q == ST_WALK) && (iss_q < nv_q);

  pip_vertex_mem #(
    .DEPTH  (MAX_VERTICES),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (ADDR_W'(in_slot)),
    .wdata_i ({in_y, in_x}),
    .re_i    (mem_re),
    .raddr_i (iss_q[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  assign rd_x = rdata[COORD_W-1:0];
  assign rd_y = rdata[VERTEX_W-1:COORD_W];

  // edge from the previous vertex to the one just read, or back to the first
  always_comb begin
    ereq      = '0;
    ereq.vld  = tag_vld_q && !tag_first_q;
    ereq.last = tag_wrap_q;
    ereq.cx   = prev_x_q;
    ereq.cy   = prev_y_q;
    ereq.nx   = tag_wrap_q ? first_x_q : rd_x;
    ereq.ny   = tag_wrap_q ? first_y_q : rd_y;
  end

  pip_edge_unit u_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ereq),
    .px_i   (pt_x_q),
    .py_i   (pt_y_q),
    .rsp_o  (ersp)
  );

  // sequencer, walk state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      nv_q          <= '0;
      iss_q         <= '0;
      tag_vld_q     <= 1'b0;
      tag_first_q   <= 1'b0;
      tag_wrap_q    <= 1'b0;
      par_q         <= 1'b0;
      pt_x_q        <= '0;
      pt_y_q        <= '0;
      first_x_q     <= '0;
      first_y_q     <= '0;
      prev_x_q      <= '0;
      prev_y_q      <= '0;
      out_vld_q     <= 1'b0;
      out_outside_q <= 1'b0;
      out_x_q       <= '0;
      out_y_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end

      // issue tags are registered in step with the table read, so they line up with the read data
      tag_vld_q   <= (state_q == ST_WALK);
      tag_first_q <= (iss_q == '0);
      tag_wrap_q  <= (iss_q == nv_q);

      // capture vertices as they come out of the table
      if (tag_vld_q && !tag_wrap_q) begin
        prev_x_q <= rd_x;
        prev_y_q <= rd_y;
        if (tag_first_q) begin
          first_x_q <= rd_x;
          first_y_q <= rd_y;
        end
      end

      // crossing parity
      if (ersp.vld && ersp.hit) begin
        par_q <= ~par_q;
      end

      // result word taken and no new one loaded in its place
      if (out_vld_q && m_axis_tready_i && (state_q != ST_DONE)) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept && !is_load) begin
            pt_x_q <= in_x;
            pt_y_q <= in_y;
            nv_q   <= nv_d;
            iss_q  <= '0;
            par_q  <= 1'b0;
            state_q <= (nv_d < CW'(2)) ? ST_DONE : ST_WALK;
          end
        end
        ST_WALK: begin
          if (iss_q == nv_q) begin
            state_q <= ST_WAIT;
          end else begin
            iss_q <= iss_q + CW'(1);
          end
        end
        ST_WAIT: begin
          if (ersp.vld && ersp.last) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_vld_q || m_axis_tready_i) begin
            out_vld_q     <= 1'b1;
            out_outside_q <= ~par_q;
            out_x_q       <= pt_x_q;
            out_y_q       <= pt_y_q;
            state_q       <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{PAD_W{1'b0}}, out_y_q, out_x_q, out_outside_q};

  // a new result word only appears after a finished test
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == ST_DONE))
    else $error("result word without a finished test");

  // edge verdicts only while a test is running
  a_rsp_in_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ersp.vld |-> (state_q == ST_WALK || state_q == ST_WAIT))
    else $error("edge verdict outside a test");

  // table reads never overlap an idle port
  a_tag_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_vld_q |-> !s_axis_tready_o)
    else $error("table read in flight while taking input");

endmodule

// ===== sv/pip_vertex_mem.sv =====
// vertex table: one write port, one read port, registered read data
// depends on pip_pkg for the vertex word width
module pip_vertex_mem
  import pip_pkg::*;
#(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [ADDR_W-1:0]   waddr_i,
  input  logic [VERTEX_W-1:0] wdata_i,
  input  logic                re_i,
  input  logic [ADDR_W-1:0]   raddr_i,
  output logic [VERTEX_W-1:0] rdata_o
);

  logic [VERTEX_W-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== sv/pip_edge_unit.sv =====
// two-stage edge crossing test: products registered, then compared
// depends on pip_pkg for the edge request and response structs
module pip_edge_unit
  import pip_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  edge_req_t          req_i,
  input  logic [COORD_W-1:0] px_i,
  input  logic [COORD_W-1:0] py_i,
  output edge_rsp_t          rsp_o
);

  logic signed [COORD_W-1:0]   cx, cy, nx, ny, px, py;
  logic signed [COORD_W:0]     d_pn_x, d_cn_y, d_pn_y, d_cn_x;
  logic                        between;
  logic signed [2*COORD_W+1:0] lhs_d, rhs_d;
  logic signed [2*COORD_W+1:0] lhs_q, rhs_q;
  logic                        between_q, dpos_q, vld_q, last_q;
  logic                        hit;

  assign cx = $signed(req_i.cx);
  assign cy = $signed(req_i.cy);
  assign nx = $signed(req_i.nx);
  assign ny = $signed(req_i.ny);
  assign px = $signed(px_i);
  assign py = $signed(py_i);

  // differences and exact products
  assign d_pn_x  = {px[COORD_W-1], px} - {nx[COORD_W-1], nx};
  assign d_cn_y  = {cy[COORD_W-1], cy} - {ny[COORD_W-1], ny};
  assign d_pn_y  = {py[COORD_W-1], py} - {ny[COORD_W-1], ny};
  assign d_cn_x  = {cx[COORD_W-1], cx} - {nx[COORD_W-1], nx};
  assign lhs_d   = d_pn_x * d_cn_y;
  assign rhs_d   = d_pn_y * d_cn_x;
  assign between = ((cx < px) && (px < nx)) || ((cx > px) && (px > nx));

  // stage one: products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= 1'b0;
      last_q    <= 1'b0;
      between_q <= 1'b0;
      dpos_q    <= 1'b0;
      lhs_q     <= '0;
      rhs_q     <= '0;
    end else begin
      vld_q     <= req_i.vld;
      last_q    <= req_i.last;
      between_q <= between;
      dpos_q    <= (d_cn_x > 0);
      lhs_q     <= lhs_d;
      rhs_q     <= rhs_d;
    end
  end

  // compare with the direction of the edge taken into account
  assign hit = between_q && (dpos_q ? (lhs_q >= rhs_q) : (lhs_q <= rhs_q));

  // stage two: verdict
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_o <= '0;
    end else begin
      rsp_o.vld  <= vld_q;
      rsp_o.last <= last_q;
      rsp_o.hit  <= hit;
    end
  end

endmodule
